### rtl/core/sctu_pkg.sv
`timescale 1ns / 1ps

package sctu_pkg;

    localparam int DEF_ANGLE_FRAC_BITS  = 24;
    localparam int DEF_RESULT_FRAC_BITS = 16;

    // angle constants with 32 fractional bits
    localparam logic [35:0] K_PI      = 36'h3_243F_6A89;
    localparam logic [35:0] K_TWO_PI  = 36'h6_487E_D511;
    localparam logic [35:0] K_HALF_PI = 36'h1_921F_B544;
    localparam logic [35:0] K_QUART   = 36'h0_C90F_DAA2;
    localparam logic [32:0] K_ONE     = 33'h1_0000_0000;

    // reciprocals for exact floor division of 32-bit values by 3 and 15
    localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP15 = 32'h8888_8889;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [1:0] {
        CMD_SIN = 2'd0,
        CMD_COS = 2'd1,
        CMD_TAN = 2'd2
    } cmd_e;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] angle;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               saturated;
    } rsp_t;

    // folded angle in [0, pi/4] with sign tracking
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] x;
        logic        big;
        logic        sn;
        logic        cn;
    } fold_t;

    // sine and cosine magnitudes with 32 fractional bits
    typedef struct packed {
        logic [1:0]  command;
        logic        sn;
        logic        cn;
        logic [32:0] sm;
        logic [32:0] cm;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [32:0] quot;
        logic        ovf;
    } quot_t;

endpackage

### rtl/core/sine_cosine_tangent_unit_top.sv
`timescale 1ns / 1ps

// the stages in order are reduction, polynomial, tangent divider and output register
// throughput: one request per cycle; every stage is pipelined, a stalled output
//   only holds the stages behind it that are full
// reset: rst_n clears all valid bits asynchronously, the pipeline comes up empty

module sine_cosine_tangent_unit_top #(
    parameter int ANGLE_FRAC_BITS  = sctu_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int RESULT_FRAC_BITS = sctu_pkg::DEF_RESULT_FRAC_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  sctu_pkg::req_t req_data,
    output logic           res_valid,
    input  logic           res_ready,
    output sctu_pkg::rsp_t res_data
);

    localparam int SH = 32 - RESULT_FRAC_BITS;
    localparam logic [33:0] HALF_LSB = 34'(1) << (SH - 1);
    localparam logic signed [31:0] RES_ONE = 32'(1) << RESULT_FRAC_BITS;

    logic            red_valid;
    logic            red_ready;
    sctu_pkg::fold_t red_data;

    logic            div_req_valid;
    logic            div_req_ready;
    sctu_pkg::side_t div_req_data;
    logic            div_res_valid;
    logic            div_res_ready;
    sctu_pkg::quot_t div_res_data;

    logic [4:0]      p_v_reg;
    logic [5:0]      en_p;

    sctu_pkg::fold_t f1_reg, f2_reg, f3_reg, f4_reg;
    logic [31:0]     x2_1_reg, x2_2_reg, x2_3_reg;
    logic [31:0]     x3_2_reg, x4_2_reg;
    logic [31:0]     x5_3_reg;
    logic [29:0]     q6_3_reg, q6_4_reg;
    logic [27:0]     q24_3_reg;
    logic [25:0]     q120_4_reg;
    logic [32:0]     pc_4_reg;
    sctu_pkg::side_t s5_reg;

    logic [63:0]     m_xx, m_x2x, m_x2x2, m_x4x, m_q6, m_q24, m_q120;
    logic [31:0]     ps;

    logic            o_valid_reg;
    logic [1:0]      o_cmd_reg;
    sctu_pkg::rsp_t  o_data_reg;
    sctu_pkg::rsp_t  o_data_next;
    logic            en_o;

    logic [31:0]     s_round, c_round;
    logic            tn;

    sctu_reduce #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (red_valid),
        .res_ready (red_ready),
        .res_data  (red_data)
    );

    // polynomial pipeline
    assign en_p[5] = div_req_ready;

    genvar i;
    generate
        for (i = 0; i < 5; i++)
        begin : g_en
            assign en_p[i] = ~p_v_reg[i] | en_p[i+1];
        end
    endgenerate

    assign red_ready = en_p[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= '0;
        end
        else
        begin
            if (en_p[0])
            begin
                p_v_reg[0] <= red_valid;
            end
            for (int k = 1; k < 5; k++)
            begin
                if (en_p[k])
                begin
                    p_v_reg[k] <= p_v_reg[k-1];
                end
            end
        end
    end

    assign m_xx   = 64'(red_data.x) * 64'(red_data.x);
    assign m_x2x  = 64'(x2_1_reg) * 64'(f1_reg.x);
    assign m_x2x2 = 64'(x2_1_reg) * 64'(x2_1_reg);
    assign m_x4x  = 64'(x4_2_reg) * 64'(f2_reg.x);
    assign m_q6   = 64'(x3_2_reg) * 64'(sctu_pkg::RECIP3);
    assign m_q24  = 64'(x4_2_reg) * 64'(sctu_pkg::RECIP3);
    assign m_q120 = 64'(x5_3_reg) * 64'(sctu_pkg::RECIP15);

    always_ff @(posedge clk)
    begin
        if (en_p[0])
        begin
            f1_reg   <= red_data;
            x2_1_reg <= m_xx[63:32];
        end
        if (en_p[1])
        begin
            f2_reg   <= f1_reg;
            x2_2_reg <= x2_1_reg;
            x3_2_reg <= m_x2x[63:32];
            x4_2_reg <= m_x2x2[63:32];
        end
        if (en_p[2])
        begin
            f3_reg    <= f2_reg;
            x2_3_reg  <= x2_2_reg;
            x5_3_reg  <= m_x4x[63:32];
            q6_3_reg  <= m_q6[63:34];
            q24_3_reg <= m_q24[63:36];
        end
        if (en_p[3])
        begin
            f4_reg     <= f3_reg;
            q6_4_reg   <= q6_3_reg;
            q120_4_reg <= m_q120[63:38];
            pc_4_reg   <= sctu_pkg::K_ONE - 33'(x2_3_reg >> 1) + 33'(q24_3_reg);
        end
        if (en_p[4])
        begin
            s5_reg.command <= f4_reg.command;
            s5_reg.sn      <= f4_reg.sn;
            s5_reg.cn      <= f4_reg.cn;
            s5_reg.sm      <= f4_reg.big ? pc_4_reg : {1'b0, ps};
            s5_reg.cm      <= f4_reg.big ? {1'b0, ps} : pc_4_reg;
        end
    end

    assign ps = f4_reg.x - 32'(q6_4_reg) + 32'(q120_4_reg);

    assign div_req_valid = p_v_reg[4];
    assign div_req_data  = s5_reg;

    sctu_div #(
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (div_req_valid),
        .req_ready (div_req_ready),
        .req_data  (div_req_data),
        .res_valid (div_res_valid),
        .res_ready (div_res_ready),
        .res_data  (div_res_data)
    );

    // result formatting
    assign en_o          = ~o_valid_reg | res_ready;
    assign div_res_ready = en_o;

    always_comb
    begin
        s_round = 32'((34'(div_res_data.side.sm) + HALF_LSB) >> SH);
        c_round = 32'((34'(div_res_data.side.cm) + HALF_LSB) >> SH);
        tn      = div_res_data.side.sn ^ div_res_data.side.cn;

        o_data_next.saturated = 1'b0;
        o_data_next.value     = '0;

        unique case (div_res_data.side.command)
            sctu_pkg::CMD_SIN:
            begin
                o_data_next.value = div_res_data.side.sn ? (32'd0 - s_round) : s_round;
            end
            sctu_pkg::CMD_COS:
            begin
                o_data_next.value = div_res_data.side.cn ? (32'd0 - c_round) : c_round;
            end
            default:
            begin
                if (div_res_data.side.cm == '0)
                begin
                    o_data_next.saturated = 1'b1;
                    o_data_next.value     = div_res_data.side.sn ? sctu_pkg::SAT_NEG
                                                                 : sctu_pkg::SAT_POS;
                end
                else if (!tn && (div_res_data.ovf || div_res_data.quot[32]
                                 || div_res_data.quot[31]))
                begin
                    o_data_next.saturated = 1'b1;
                    o_data_next.value     = sctu_pkg::SAT_POS;
                end
                else if (tn && (div_res_data.ovf
                                || div_res_data.quot > 33'(sctu_pkg::SAT_NEG)))
                begin
                    o_data_next.saturated = 1'b1;
                    o_data_next.value     = sctu_pkg::SAT_NEG;
                end
                else
                begin
                    o_data_next.value = tn ? (32'd0 - div_res_data.quot[31:0])
                                           : div_res_data.quot[31:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en_o)
        begin
            o_valid_reg <= div_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            o_data_reg <= o_data_next;
            o_cmd_reg  <= div_res_data.side.command;
        end
    end

    assign res_valid = o_valid_reg;
    assign res_data  = o_data_reg;

    // a free output slot lets every stage move
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid || res_ready) |-> req_ready)
        else $error("request refused while output free");

    a_sincos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (o_cmd_reg == sctu_pkg::CMD_SIN || o_cmd_reg == sctu_pkg::CMD_COS))
        |-> (!res_data.saturated && res_data.value <= RES_ONE && res_data.value >= -RES_ONE))
        else $error("sine or cosine result out of range");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.saturated)
        |-> (res_data.value == sctu_pkg::SAT_POS || res_data.value == sctu_pkg::SAT_NEG))
        else $error("saturated result not at a limit");

endmodule

### rtl/core/sctu_reduce.sv
`timescale 1ns / 1ps

module sctu_reduce #(
    parameter int ANGLE_FRAC_BITS = sctu_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sctu_pkg::req_t    req_data,
    output logic              res_valid,
    input  logic              res_ready,
    output sctu_pkg::fold_t   res_data
);

    localparam int XW = 64 - ANGLE_FRAC_BITS;
    localparam int DS = XW - 34;
    localparam int NS = DS + 3;

    logic [NS-1:0]   v_reg;
    logic [NS:0]     en;

    logic [XW-1:0]   r_reg   [0:DS];
    logic [1:0]      cmd_reg [0:DS];
    logic            neg_reg [0:DS];

    logic [33:0]     r1_reg;
    logic [1:0]      cmd1_reg;
    logic            sn1_reg;
    logic            p1_reg;

    sctu_pkg::fold_t f_reg;

    logic [31:0]     mag;
    logic [XW-1:0]   x_entry;

    logic [34:0]     rm;
    logic            p_next;
    logic [33:0]     r1_next;
    logic            h;
    logic [32:0]     r2;
    logic            big;
    logic [31:0]     r3;

    assign en[NS] = res_ready;

    genvar i;
    generate
        for (i = 0; i < NS; i++)
        begin : g_en
            assign en[i] = ~v_reg[i] | en[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= req_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // magnitude moved to 32 fractional bits
    always_comb
    begin
        mag     = req_data.angle[31] ? (32'd0 - 32'(req_data.angle)) : 32'(req_data.angle);
        x_entry = {mag, {(32 - ANGLE_FRAC_BITS){1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg[0]   <= x_entry;
            cmd_reg[0] <= req_data.command;
            neg_reg[0] <= req_data.angle[31];
        end
    end

    // restoring reduction modulo two pi, one quotient bit per stage
    genvar j;
    generate
        for (j = 1; j <= DS; j++)
        begin : g_mod
            localparam int SH = DS - j;
            logic [XW-1:0] sub_w;
            logic          ge_w;

            assign sub_w = XW'(sctu_pkg::K_TWO_PI) << SH;
            assign ge_w  = r_reg[j-1] >= sub_w;

            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    r_reg[j]   <= ge_w ? (r_reg[j-1] - sub_w) : r_reg[j-1];
                    cmd_reg[j] <= cmd_reg[j-1];
                    neg_reg[j] <= neg_reg[j-1];
                end
            end
        end
    endgenerate

    // fold above pi
    always_comb
    begin
        rm      = r_reg[DS][34:0];
        p_next  = rm > 35'(sctu_pkg::K_PI);
        r1_next = p_next ? 34'(rm - 35'(sctu_pkg::K_PI)) : rm[33:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[DS+1])
        begin
            r1_reg   <= r1_next;
            cmd1_reg <= cmd_reg[DS];
            sn1_reg  <= neg_reg[DS] ^ p_next;
            p1_reg   <= p_next;
        end
    end

    // fold above pi/2, then above pi/4
    always_comb
    begin
        h   = r1_reg > 34'(sctu_pkg::K_HALF_PI);
        r2  = h ? 33'(34'(sctu_pkg::K_PI) - r1_reg) : r1_reg[32:0];
        big = r2 > 33'(sctu_pkg::K_QUART);
        r3  = big ? 32'(33'(sctu_pkg::K_HALF_PI) - r2) : r2[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[DS+2])
        begin
            f_reg.command <= cmd1_reg;
            f_reg.x       <= r3;
            f_reg.big     <= big;
            f_reg.sn      <= sn1_reg;
            f_reg.cn      <= p1_reg ^ h;
        end
    end

    assign req_ready = en[0];
    assign res_valid = v_reg[NS-1];
    assign res_data  = f_reg;

endmodule

### rtl/core/sctu_div.sv
`timescale 1ns / 1ps

module sctu_div #(
    parameter int RESULT_FRAC_BITS = sctu_pkg::DEF_RESULT_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sctu_pkg::side_t   req_data,
    output logic              res_valid,
    input  logic              res_ready,
    output sctu_pkg::quot_t   res_data
);

    localparam int NW = 34 + RESULT_FRAC_BITS;
    localparam int HW = NW - 33;
    localparam int QB = 33;
    localparam int NS = QB + 1;

    logic [NS-1:0]   v_reg;
    logic [NS:0]     en;

    logic [32:0]     rem_reg  [0:QB];
    logic [32:0]     lo_reg   [0:QB];
    logic [32:0]     q_reg    [0:QB];
    logic            ovf_reg  [0:QB];
    sctu_pkg::side_t side_reg [0:QB];

    logic [NW-1:0]   num;
    logic [HW-1:0]   hi;

    assign en[NS] = res_ready;

    genvar i;
    generate
        for (i = 0; i < NS; i++)
        begin : g_en
            assign en[i] = ~v_reg[i] | en[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= req_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // dividend with half the divisor added for rounding
    always_comb
    begin
        num = (NW'(req_data.sm) << RESULT_FRAC_BITS) + NW'(req_data.cm >> 1);
        hi  = num[NW-1:33];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= 33'(hi);
            lo_reg[0]   <= num[32:0];
            q_reg[0]    <= '0;
            ovf_reg[0]  <= 34'(hi) >= 34'(req_data.cm);
            side_reg[0] <= req_data;
        end
    end

    // restoring division, one quotient bit per stage
    genvar j;
    generate
        for (j = 1; j <= QB; j++)
        begin : g_step
            logic [33:0] t_w;
            logic [33:0] d_w;
            logic        ge_w;

            assign t_w  = {rem_reg[j-1], lo_reg[j-1][32]};
            assign d_w  = {1'b0, side_reg[j-1].cm};
            assign ge_w = t_w >= d_w;

            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    rem_reg[j]  <= ge_w ? 33'(t_w - d_w) : t_w[32:0];
                    lo_reg[j]   <= {lo_reg[j-1][31:0], 1'b0};
                    q_reg[j]    <= {q_reg[j-1][31:0], ge_w};
                    ovf_reg[j]  <= ovf_reg[j-1];
                    side_reg[j] <= side_reg[j-1];
                end
            end
        end
    endgenerate

    assign req_ready     = en[0];
    assign res_valid     = v_reg[NS-1];
    assign res_data.side = side_reg[QB];
    assign res_data.quot = q_reg[QB];
    assign res_data.ovf  = ovf_reg[QB];

endmodule

### sim/tb_sine_cosine_tangent_unit_top.sv
`timescale 1ns / 1ps

module tb_sine_cosine_tangent_unit_top;

    localparam int AFB = sctu_pkg::DEF_ANGLE_FRAC_BITS;
    localparam int RFB = sctu_pkg::DEF_RESULT_FRAC_BITS;
    localparam int LATENCY = 73 - AFB;
    localparam int N_RANDOM = 2000;
    localparam int WATCHDOG = 20000;
    localparam logic [63:0] PI64 = 64'h3_243F_6A89;
    localparam logic [63:0] TWO_PI64 = 64'h6_487E_D511;
    localparam logic [63:0] HALF_PI64 = 64'h1_921F_B544;
    localparam logic [63:0] QUART64 = 64'h0_C90F_DAA2;
    localparam logic [63:0] ONE64 = 64'h1_0000_0000;

    typedef struct {
        logic [1:0]     command;
        logic [31:0]    angle;
        bit             known;
        sctu_pkg::rsp_t rsp;
    } vector_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    sctu_pkg::req_t req_data;
    logic res_valid;
    logic res_ready;
    sctu_pkg::rsp_t res_data;

    sctu_pkg::rsp_t pending_results[$];
    vector_t vectors[$];
    int errors;
    int n_sent;
    int n_checked;
    int n_tan_sat;
    int idle_cycles;
    bit stimulus_done;
    bit quiet;

    sine_cosine_tangent_unit_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data(res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] taylor_sin(logic [63:0] x);
        logic [63:0] x2, x3, x4, x5;
        x2 = (x * x) >> 32;
        x3 = (x2 * x) >> 32;
        x4 = (x2 * x2) >> 32;
        x5 = (x4 * x) >> 32;
        return x - x3 / 6 + x5 / 120;
    endfunction

    function automatic logic [63:0] taylor_cos(logic [63:0] x);
        logic [63:0] x2, x4;
        x2 = (x * x) >> 32;
        x4 = (x2 * x2) >> 32;
        return ONE64 - (x2 >> 1) + x4 / 24;
    endfunction

    function automatic logic [63:0] folded_trig(bit is_cos, logic [63:0] mag, bit neg,
                                                 output bit rneg);
        logic [63:0] r;
        bit flip;
        bit use_sin;
        r = mag % TWO_PI64;
        if (!is_cos)
        begin
            flip = neg;
            if (r > PI64)
            begin
                r = r - PI64;
                flip = !flip;
            end
            if (r > HALF_PI64)
                r = PI64 - r;
            use_sin = !(r > QUART64);
            if (!use_sin)
                r = HALF_PI64 - r;
        end
        else
        begin
            flip = 1'b0;
            if (r > PI64)
            begin
                r = r - PI64;
                flip = 1'b1;
            end
            if (r > HALF_PI64)
            begin
                r = PI64 - r;
                flip = !flip;
            end
            use_sin = (r > QUART64);
            if (use_sin)
                r = HALF_PI64 - r;
        end
        rneg = flip;
        return use_sin ? taylor_sin(r) : taylor_cos(r);
    endfunction

    function automatic logic [31:0] round_signed(logic [63:0] m, bit neg);
        logic [63:0] q;
        q = (m + (64'd1 << (31 - RFB))) >> (32 - RFB);
        return neg ? 32'd0 - q[31:0] : q[31:0];
    endfunction

    function automatic sctu_pkg::rsp_t predict_trig(logic [1:0] command, logic [31:0] angle);
        sctu_pkg::rsp_t r;
        bit neg, sn, cn, tn;
        logic [63:0] mag, x, sm, cm, q;
        neg = angle[31];
        mag = neg ? 64'h1_0000_0000 - {32'd0, angle} : {32'd0, angle};
        x = mag << (32 - AFB);
        r.saturated = 1'b0;
        if (command == sctu_pkg::CMD_SIN)
        begin
            sm = folded_trig(1'b0, x, neg, sn);
            r.value = round_signed(sm, sn);
        end
        else if (command == sctu_pkg::CMD_COS)
        begin
            cm = folded_trig(1'b1, x, neg, cn);
            r.value = round_signed(cm, cn);
        end
        else
        begin
            sm = folded_trig(1'b0, x, neg, sn);
            cm = folded_trig(1'b1, x, neg, cn);
            if (cm == 0)
            begin
                r.value = sn ? sctu_pkg::SAT_NEG : sctu_pkg::SAT_POS;
                r.saturated = 1'b1;
            end
            else
            begin
                tn = sn != cn;
                q = ((sm << RFB) + (cm >> 1)) / cm;
                if (!tn && q > 64'h7FFF_FFFF)
                begin
                    r.value = sctu_pkg::SAT_POS;
                    r.saturated = 1'b1;
                end
                else if (tn && q > 64'h8000_0000)
                begin
                    r.value = sctu_pkg::SAT_NEG;
                    r.saturated = 1'b1;
                end
                else
                    r.value = tn ? 32'd0 - q[31:0] : q[31:0];
            end
        end
        return r;
    endfunction

    function automatic vector_t row(logic [1:0] c, logic [31:0] a, bit k = 0,
                                    logic [31:0] v = 0, bit s = 0);
        vector_t t;
        t.command = c;
        t.angle = a;
        t.known = k;
        t.rsp.value = v;
        t.rsp.saturated = s;
        return t;
    endfunction

    function automatic logic [31:0] random_angle();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0700_0000) - 32'h0380_0000;
            2: return (32'h0192_1FB5 * $urandom_range(0, 8)) + $urandom_range(0, 8) - 4;
            3: return 32'd0 - ((32'h0192_1FB5 * $urandom_range(0, 8)) + $urandom_range(0, 8));
            default: return $urandom_range(0, 32'h0006_4880);
        endcase
    endfunction

    task automatic send(vector_t t);
        sctu_pkg::rsp_t exp_rsp;
        exp_rsp = t.known ? t.rsp : predict_trig(t.command, t.angle);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data.command <= t.command;
        req_data.angle <= t.angle;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_results.push_back(exp_rsp);
        n_sent++;
    endtask

    initial
    begin
        logic [1:0] c;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        errors = 0;
        n_sent = 0;
        stimulus_done = 1'b0;
        quiet = 1'b0;
        vectors.push_back(row(sctu_pkg::CMD_SIN, 32'h0, 1, 32'h0, 0));
        vectors.push_back(row(sctu_pkg::CMD_COS, 32'h0, 1, 32'h0001_0000, 0));
        vectors.push_back(row(sctu_pkg::CMD_TAN, 32'h0, 1, 32'h0, 0));
        vectors.push_back(row(2'd3, 32'h0, 1, 32'h0, 0));
        for (int i = 0; i < 3; i++)
        begin
            c = i[1:0];
            vectors.push_back(row(c, 32'h7FFF_FFFF));
            vectors.push_back(row(c, 32'h8000_0000));
            vectors.push_back(row(c, 32'h0192_1FB5));
            vectors.push_back(row(c, 32'h0324_3F6A));
            vectors.push_back(row(c, 32'h0324_3F6B));
            vectors.push_back(row(c, 32'hFF36_F026));
        end
        vectors.push_back(row(sctu_pkg::CMD_TAN, 32'h0192_1FB4));
        vectors.push_back(row(sctu_pkg::CMD_TAN, 32'hFE6D_E04B));
        vectors.push_back(row(2'd3, 32'h00C9_0FDA));
        vectors.push_back(row(sctu_pkg::CMD_TAN, 32'hFFFF_FFFF));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (vectors[i])
            send(vectors[i]);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i > N_RANDOM - 200)
                quiet = 1'b1;
            send(row(2'($urandom_range(0, 3)), random_angle()));
        end
        req_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin
        res_ready = 1'b0;
        n_checked = 0;
        n_tan_sat = 0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request outstanding: value %h", res_data.value);
                    errors++;
                end
                else
                begin
                    sctu_pkg::rsp_t exp_rsp;
                    exp_rsp = pending_results.pop_front();
                    if (res_data.value !== exp_rsp.value)
                    begin
                        $error("value: expected %h, actual %h", exp_rsp.value, res_data.value);
                        errors++;
                    end
                    if (res_data.saturated !== exp_rsp.saturated)
                    begin
                        $error("saturated: expected %b, actual %b",
                               exp_rsp.saturated, res_data.saturated);
                        errors++;
                    end
                    if (exp_rsp.saturated)
                        n_tan_sat++;
                    n_checked++;
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("timeout with %0d results outstanding", pending_results.size());
                $display("CHECKS FAILED");
                $finish;
            end
            if (stimulus_done && pending_results.size() == 0)
            begin
                repeat (LATENCY + 10) @(posedge clk);
                $display("sent %0d requests, checked %0d results, %0d saturated tangents",
                         n_sent, n_checked, n_tan_sat);
                if (errors == 0 && pending_results.size() == 0)
                    $display("ALL CHECKS PASSED");
                else
                    $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
